@@ hdl/prq_pkg.sv @@
// ----------------------------------------------------------------------------
// prq_pkg: shared types and constants for the priority ready queue
// Slot count, field widths, command and status codes.
// ----------------------------------------------------------------------------
`default_nettype none
package prq_pkg;
  localparam int NumSlots = 16;
  localparam int SlotW    = $clog2(NumSlots);
  localparam int CntW     = $clog2(NumSlots + 1);

  typedef logic [1:0]  cmd_t;
  typedef logic [2:0]  status_t;
  typedef logic [1:0]  cfg_idx_t;
  typedef logic [SlotW-1:0] slot_t;

  localparam cmd_t CMD_INSERT = 2'd0;
  localparam cmd_t CMD_POP    = 2'd1;
  localparam cmd_t CMD_TICK   = 2'd2;

  localparam status_t ST_INSERTED  = 3'd0;
  localparam status_t ST_DUPLICATE = 3'd1;
  localparam status_t ST_BAD_PRIO  = 3'd2;
  localparam status_t ST_FULL      = 3'd3;
  localparam status_t ST_POPPED    = 3'd4;
  localparam status_t ST_EMPTY     = 3'd5;
  localparam status_t ST_TICK      = 3'd6;

  localparam cfg_idx_t CFG_THRESH = 2'd0;
  localparam cfg_idx_t CFG_INCR   = 2'd1;
  localparam cfg_idx_t CFG_STEP   = 2'd2;
  localparam cfg_idx_t CFG_PMAX   = 2'd3;

  // one slot entry as stored in memory
  typedef struct packed {
    logic [7:0]  id;
    logic [7:0]  prio;
    logic [15:0] wait_t;
  } entry_t;

  // one memory access request
  typedef struct packed {
    logic   we;
    slot_t  addr;
    entry_t wdata;
  } mem_req_t;
endpackage
`default_nettype wire

@@ hdl/priority_ready_queue_with_aging.sv @@
// ----------------------------------------------------------------------------
// priority_ready_queue_with_aging: ready queue of task slots with aging
// Insert / pop-best / tick commands over a slot memory scanned one slot
// per cycle, except while a tick write-back holds the port.
// ----------------------------------------------------------------------------
// Channel   Direction  Ports                                   Handshake
// in        input      in_cmd, in_task_id, in_task_priority    start & !busy
// out       output     out_status, out_id, out_priority,       out_valid strobe
//                      out_occupancy
// cfg       input      cfg_we, cfg_index, cfg_data             cfg_we
//
// Insert, pop and the unused command make one scan pass over the slot memory,
// one read per cycle, then drain the last read and end in S_FINISH, which
// writes the inserted entry. A tick also writes back every queued slot, each
// write taking the port in place of a read, so its scan reads are held while
// a write-back is pending.
// Valid bits are flip-flops cleared by reset; slot memory needs no clearing.
// busy is high from accept until the result strobe. The receiver cannot
// stall: out_valid lasts one cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module priority_ready_queue_with_aging (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [7:0]  in_task_id,
  input  wire logic signed [8:0] in_task_priority,
  output logic             out_valid,
  output logic [2:0]       out_status,
  output logic [7:0]       out_id,
  output logic [7:0]       out_priority,
  output logic [4:0]       out_occupancy,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import prq_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINISH} state_t;

  state_t state_r;
  logic [15:0] thresh_r, incr_r;
  logic [7:0]  step_r, pmax_r;
  logic [NumSlots-1:0] valid_r;
  cmd_t        cmd_r;
  logic [7:0]  id_r;
  logic [8:0]  prio_r;
  logic [CntW-1:0] idx_r;      // address issued this cycle
  logic        rd_v_r;         // rdata belongs to slot rd_slot_r
  slot_t       rd_slot_r;
  logic        dup_r, free_v_r, best_v_r;
  slot_t       free_r, best_r;
  logic [7:0]  best_id_r, best_pr_r;
  mem_req_t    req;
  entry_t      rdata, aged;
  logic [16:0] wsum;
  logic [8:0]  psum;
  logic        scan_done;

  prq_mem u_mem (.clk(clk), .req(req), .rdata(rdata));

  // tick update of the slot just read
  always_comb begin
    wsum = {1'b0, rdata.wait_t} + {1'b0, incr_r};
    aged = rdata;
    aged.wait_t = wsum[16] ? 16'hFFFF : wsum[15:0];
    psum = {1'b0, rdata.prio} + {1'b0, step_r};
    if (aged.wait_t >= thresh_r && rdata.id != 8'd0)
      aged.prio = (psum > {1'b0, pmax_r}) ? pmax_r : psum[7:0];
  end

  assign scan_done = (idx_r == CntW'(NumSlots));

  // memory port: scan reads; tick writes back the previous slot; finish
  // writes the inserted entry
  always_comb begin
    req = '0;
    if (state_r == S_SCAN && cmd_r == CMD_TICK && rd_v_r && valid_r[rd_slot_r]) begin
      req.we    = 1'b1;
      req.addr  = rd_slot_r;
      req.wdata = aged;
    end else if (state_r == S_SCAN && !scan_done) begin
      req.addr = idx_r[SlotW-1:0];
    end else if (state_r == S_FINISH) begin
      req.we    = (cmd_r == CMD_INSERT) && !prio_r[8] && (prio_r[7:0] <= pmax_r)
                  && !dup_r && free_v_r;
      req.addr  = free_r;
      req.wdata = '{id: id_r, prio: prio_r[7:0], wait_t: 16'd0};
    end
  end

  // tick writes steal the port from the scan reads, so issue a read only when
  // no write-back is pending
  logic issue;
  assign issue = (state_r == S_SCAN) && !scan_done && !req.we;

  logic [NumSlots-1:0] valid_nxt;
  logic ins_ok;
  always_comb begin
    ins_ok = !prio_r[8] && (prio_r[7:0] <= pmax_r) && !dup_r && free_v_r;
    valid_nxt = valid_r;
    if (cmd_r == CMD_INSERT && ins_ok) valid_nxt[free_r] = 1'b1;
    if (cmd_r == CMD_POP && best_v_r)  valid_nxt[best_r] = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      thresh_r  <= 16'd1500;
      incr_r    <= 16'd100;
      step_r    <= 8'd10;
      pmax_r    <= 8'd149;
      valid_r   <= '0;
      busy      <= 1'b0;
      out_valid <= 1'b0;
      rd_v_r    <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_THRESH: thresh_r <= cfg_data;
          CFG_INCR:   incr_r   <= cfg_data;
          CFG_STEP:   step_r   <= cfg_data[7:0];
          CFG_PMAX:   pmax_r   <= cfg_data[7:0];
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          rd_v_r <= 1'b0;
          if (start) begin
            state_r  <= S_SCAN;
            busy     <= 1'b1;
            cmd_r    <= in_cmd;
            id_r     <= in_task_id;
            prio_r   <= in_task_priority;
            idx_r    <= '0;
            dup_r    <= 1'b0;
            free_v_r <= 1'b0;
            best_v_r <= 1'b0;
          end
        end
        S_SCAN: begin
          // evaluate slot read last cycle
          if (rd_v_r && valid_r[rd_slot_r]) begin
            if (rdata.id == id_r) dup_r <= 1'b1;
            if (!best_v_r || rdata.prio > best_pr_r ||
                (rdata.prio == best_pr_r && rdata.id < best_id_r)) begin
              best_v_r  <= 1'b1;
              best_r    <= rd_slot_r;
              best_id_r <= rdata.id;
              best_pr_r <= rdata.prio;
            end
          end
          if (issue && !valid_r[idx_r[SlotW-1:0]] && !free_v_r) begin
            free_v_r <= 1'b1;
            free_r   <= idx_r[SlotW-1:0];
          end
          rd_v_r    <= issue;
          rd_slot_r <= idx_r[SlotW-1:0];
          if (issue) idx_r <= idx_r + 1'b1;
          if (scan_done && !rd_v_r && !req.we) state_r <= S_FINISH;
        end
        S_FINISH: begin
          state_r   <= S_IDLE;
          busy      <= 1'b0;
          out_valid <= 1'b1;
          valid_r   <= valid_nxt;
          out_id       <= '0;
          out_priority <= '0;
          out_occupancy <= 5'($countones(valid_nxt));
          priority if (cmd_r == CMD_INSERT) begin
            out_status <= prio_r[8] || prio_r[7:0] > pmax_r ? ST_BAD_PRIO :
                          dup_r ? ST_DUPLICATE : free_v_r ? ST_INSERTED : ST_FULL;
          end else if (cmd_r == CMD_POP) begin
            out_status <= best_v_r ? ST_POPPED : ST_EMPTY;
            if (best_v_r) begin
              out_id       <= best_id_r;
              out_priority <= best_pr_r;
            end
          end else begin
            out_status <= ST_TICK;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // result strobe only after a busy period
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result without transaction");
  a_busy_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid) else $error("busy fell without result");
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH && cmd_r == CMD_POP && best_v_r) |-> valid_r[best_r])
    else $error("popping empty slot");
endmodule
`default_nettype wire

@@ hdl/prq_mem.sv @@
// ----------------------------------------------------------------------------
// prq_mem: slot storage
// Single-port synchronous memory with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module prq_mem (
  input  wire logic            clk,
  input  wire prq_pkg::mem_req_t req,
  output prq_pkg::entry_t      rdata
);
  import prq_pkg::*;
  entry_t mem [NumSlots];
  always_ff @(posedge clk) begin
    if (req.we) mem[req.addr] <= req.wdata;
    rdata <= mem[req.addr];
  end
endmodule
`default_nettype wire

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for priority_ready_queue_with_aging
// Directed and random insert/pop/tick/unused-command traffic against an in-bench scheduler
// predictor; every result strobe is compared field by field in order.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import prq_pkg::*;

  localparam int WatchdogLimit = 20000;
  localparam int DrainCycles   = 40;
  localparam cmd_t CmdUnused   = 2'd3;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [1:0] in_cmd;
  logic [7:0] in_task_id;
  logic signed [8:0] in_task_priority;
  logic out_valid;
  logic [2:0] out_status;
  logic [7:0] out_id;
  logic [7:0] out_priority;
  logic [4:0] out_occupancy;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;

  priority_ready_queue_with_aging u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_task_id(in_task_id), .in_task_priority(in_task_priority),
    .out_valid(out_valid), .out_status(out_status), .out_id(out_id),
    .out_priority(out_priority), .out_occupancy(out_occupancy),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // expected outcome of one command
  typedef struct packed {
    status_t    status;
    logic [7:0] id;
    logic [7:0] prio;
    logic [4:0] occ;
  } sched_result_t;

  // predictor copy of the queue and its registers
  logic        q_valid [NumSlots];
  logic [7:0]  q_id    [NumSlots];
  logic [7:0]  q_prio  [NumSlots];
  logic [15:0] q_wait  [NumSlots];
  logic [15:0] r_thresh;
  logic [15:0] r_incr;
  logic [7:0]  r_step;
  logic [7:0]  r_pmax;

  sched_result_t pending_results[$];
  bit failed;
  int idle_cycles;
  int send_gap_pct;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [4:0] queue_count();
    int n;
    n = 0;
    for (int i = 0; i < NumSlots; i++) if (q_valid[i]) n++;
    return n[4:0];
  endfunction

  // scheduler behavior: returns the result one command should produce
  function automatic sched_result_t schedule_cmd(cmd_t c, logic [7:0] id,
                                                 logic [8:0] p9);
    sched_result_t r;
    int slot_free;
    int best;
    logic [16:0] w;
    logic [8:0] np;
    r = '0;
    r.status = ST_TICK;
    if (c == CMD_INSERT) begin
      slot_free = -1;
      r.status = ST_INSERTED;
      // priority first, then duplicate, then space
      if (p9[8] || p9 > {1'b0, r_pmax}) begin
        r.status = ST_BAD_PRIO;
      end else begin
        for (int i = 0; i < NumSlots; i++) begin
          if (q_valid[i]) begin
            if (q_id[i] == id) r.status = ST_DUPLICATE;
          end else if (slot_free < 0) begin
            slot_free = i;
          end
        end
        if (r.status == ST_INSERTED && slot_free < 0) r.status = ST_FULL;
        if (r.status == ST_INSERTED) begin
          q_valid[slot_free] = 1'b1;
          q_id[slot_free]    = id;
          q_prio[slot_free]  = p9[7:0];
          q_wait[slot_free]  = '0;
        end
      end
    end else if (c == CMD_POP) begin
      best = -1;
      for (int i = 0; i < NumSlots; i++) begin
        if (q_valid[i] && (best < 0 || q_prio[i] > q_prio[best] ||
            (q_prio[i] == q_prio[best] && q_id[i] < q_id[best]))) best = i;
      end
      if (best < 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.status = ST_POPPED;
        r.id = q_id[best];
        r.prio = q_prio[best];
        q_valid[best] = 1'b0;
      end
    end else if (c == CMD_TICK) begin
      for (int i = 0; i < NumSlots; i++) begin
        if (q_valid[i]) begin
          w = {1'b0, q_wait[i]} + {1'b0, r_incr};
          if (w[16]) w = 17'hFFFF;
          q_wait[i] = w[15:0];
          // id zero keeps counting but never ages
          if (w[15:0] >= r_thresh && q_id[i] != 8'd0) begin
            np = {1'b0, q_prio[i]} + {1'b0, r_step};
            if (np > {1'b0, r_pmax}) np = {1'b0, r_pmax};
            q_prio[i] = np[7:0];
          end
        end
      end
    end
    r.occ = queue_count();
    return r;
  endfunction

  // one transaction: optional random gap, then hold start until accepted
  task automatic send_cmd(cmd_t c, logic [7:0] id, logic [8:0] p9);
    while ($urandom_range(99) < send_gap_pct) @(posedge clk);
    start <= 1'b1;
    in_cmd <= c;
    in_task_id <= id;
    in_task_priority <= p9;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(schedule_cmd(c, id, p9));
    start <= 1'b0;
    // block is busy for this cycle anyway
    @(posedge clk);
  endtask

  // block is idle once nothing is outstanding and busy has dropped
  task automatic wait_quiet();
    while (pending_results.size() != 0 || busy) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
    wait_quiet();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_THRESH: r_thresh = val;
      CFG_INCR:   r_incr = val;
      CFG_STEP:   r_step = val[7:0];
      default:    r_pmax = val[7:0];
    endcase
  endtask

  // result checker: strobe cannot be stalled, so sample on every edge
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result st=%0d id=%0d pr=%0d occ=%0d", $time,
                 out_status, out_id, out_priority, out_occupancy);
        failed = 1'b1;
      end else begin
        sched_result_t e;
        e = pending_results.pop_front();
        if (out_status !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, out_status);
          failed = 1'b1;
        end
        if (out_id !== e.id) begin
          $display("%0t: id expected %0d actual %0d", $time, e.id, out_id);
          failed = 1'b1;
        end
        if (out_priority !== e.prio) begin
          $display("%0t: priority expected %0d actual %0d", $time, e.prio, out_priority);
          failed = 1'b1;
        end
        if (out_occupancy !== e.occ) begin
          $display("%0t: occupancy expected %0d actual %0d", $time, e.occ, out_occupancy);
          failed = 1'b1;
        end
      end
    end
  end

  // watchdog: any accepted transaction or result resets the idle count
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // corner cases: bad priorities, duplicates, full, empty, id zero, cmd 3
  task automatic test_directed();
    send_cmd(CMD_POP, 8'd0, 9'd0);
    send_cmd(CMD_INSERT, 8'd5, 9'h1FF);
    send_cmd(CMD_INSERT, 8'd5, 9'h100);
    send_cmd(CMD_INSERT, 8'd5, 9'd150);
    send_cmd(CMD_INSERT, 8'd0, 9'd149);
    send_cmd(CMD_INSERT, 8'd255, 9'd0);
    send_cmd(CMD_INSERT, 8'd0, 9'd3);
    for (int i = 1; i <= 15; i++) send_cmd(CMD_INSERT, 8'(i * 16), 9'd149);
    send_cmd(CMD_INSERT, 8'd77, 9'd1);
    send_cmd(CmdUnused, 8'hAA, 9'h0AA);
    repeat (16) send_cmd(CMD_TICK, 8'd0, 9'd0);
    for (int i = 0; i < 17; i++) send_cmd(CMD_POP, 8'd0, 9'd0);
  endtask

  // aging under changing registers, extremes included
  task automatic test_aging_regs();
    write_reg(CFG_PMAX, 16'd255);
    write_reg(CFG_STEP, 16'd255);
    write_reg(CFG_INCR, 16'hFFFF);
    write_reg(CFG_THRESH, 16'hFFFF);
    send_cmd(CMD_INSERT, 8'd1, 9'd255);
    send_cmd(CMD_INSERT, 8'd2, 9'd200);
    send_cmd(CMD_INSERT, 8'd0, 9'd0);
    send_cmd(CMD_TICK, 8'd0, 9'd0);
    send_cmd(CMD_TICK, 8'd0, 9'd0);
    // lower the cap below queued priorities: aging clamps down
    write_reg(CFG_PMAX, 16'd0);
    write_reg(CFG_STEP, 16'd0);
    write_reg(CFG_THRESH, 16'd0);
    write_reg(CFG_INCR, 16'd0);
    send_cmd(CMD_INSERT, 8'd9, 9'd0);
    send_cmd(CMD_INSERT, 8'd8, 9'd1);
    send_cmd(CMD_TICK, 8'd0, 9'd0);
    repeat (4) send_cmd(CMD_POP, 8'd0, 9'd0);
  endtask

  // random traffic; each phase runs under its own random register setting
  task automatic test_random(int n);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 45)
        send_cmd(CMD_INSERT, 8'($urandom_range(r < 30 ? 31 : 255)),
                 (r < 40) ? 9'($urandom_range(r_pmax)) : 9'($urandom));
      else if (r < 70) send_cmd(CMD_POP, 8'($urandom), 9'($urandom));
      else if (r < 98) send_cmd(CMD_TICK, 8'($urandom), 9'($urandom));
      else send_cmd(CmdUnused, 8'($urandom), 9'($urandom));
    end
  endtask

  task automatic set_random_regs();
    write_reg(CFG_THRESH, 16'($urandom_range(3000)));
    write_reg(CFG_INCR, 16'($urandom_range(2) == 0 ? $urandom : $urandom_range(600)));
    write_reg(CFG_STEP, 16'($urandom_range(40)));
    write_reg(CFG_PMAX, 16'($urandom_range(100, 255)));
  endtask

  initial begin
    failed = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_cmd = CMD_INSERT;
    in_task_id = '0;
    in_task_priority = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_THRESH;
    cfg_data = '0;
    send_gap_pct = 22;
    r_thresh = 16'd1500;
    r_incr = 16'd100;
    r_step = 8'd10;
    r_pmax = 8'd149;
    for (int i = 0; i < NumSlots; i++) begin
      q_valid[i] = 1'b0;
      q_id[i] = '0;
      q_prio[i] = '0;
      q_wait[i] = '0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_aging_regs();
    set_random_regs();
    test_random(230);
    send_gap_pct = 87;
    set_random_regs();
    test_random(230);
    // hold off until the queue has answered everything
    wait_quiet();
    send_gap_pct = 0;
    set_random_regs();
    test_random(200);

    wait_quiet();
    repeat (DrainCycles) @(posedge clk);
    if (!failed && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ filelist.f @@
hdl/prq_pkg.sv
hdl/prq_mem.sv
hdl/priority_ready_queue_with_aging.sv
tb/tb.sv
